[rtl/core/pce_pkg.sv]
// shared types, constants and functions of the patch control tuple encoder
`timescale 1ns / 1ps
`default_nettype none

package pce_pkg;

   localparam int POS_BITS       = 32;
   localparam int FIELD_BITS     = 32;
   localparam int WORD_BITS      = 64;
   localparam int SIGN_BIT       = 63;
   localparam int JOB_WORDS      = 4;
   localparam int JOB_IDX_BITS   = $clog2(JOB_WORDS);
   localparam int QUEUE_DEPTH    = 2;
   localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_BITS = $clog2(QUEUE_DEPTH + 1);

   localparam logic CMD_SEGMENT = 1'b0;
   localparam logic CMD_FINISH  = 1'b1;

   typedef logic [FIELD_BITS-1:0] field_type;
   typedef logic [POS_BITS-1:0]   pos_type;
   typedef logic [WORD_BITS-1:0]  word_type;

   typedef struct packed {
      logic [JOB_IDX_BITS-1:0]          last_idx;
      logic                             fin;
      logic [JOB_WORDS-1:0][WORD_BITS-1:0] words;
   } job_type;

   function automatic word_type to_sign_mag(input word_type v);
      word_type neg;
      neg = ~v + word_type'(1);
      return v[SIGN_BIT] ? {1'b1, neg[SIGN_BIT-1:0]} : v;
   endfunction

endpackage

`default_nettype wire

[rtl/core/pce_req_if.sv]
// input item channel of the encoder
`timescale 1ns / 1ps
`default_nettype none

interface pce_req_if import pce_pkg::*; ();
   logic      valid;
   logic      ready;
   logic      command;
   field_type seg_new_pos;
   field_type seg_old_pos;
   field_type seg_length;

   modport source (output valid, command, seg_new_pos, seg_old_pos, seg_length,
                   input ready);
   modport sink (input valid, command, seg_new_pos, seg_old_pos, seg_length,
                 output ready);
endinterface

`default_nettype wire

[rtl/core/pce_rsp_if.sv]
// result item channel of the encoder
`timescale 1ns / 1ps
`default_nettype none

interface pce_rsp_if import pce_pkg::*; ();
   logic     valid;
   logic     ready;
   word_type encoded_word;
   logic     last;

   modport source (output valid, encoded_word, last, input ready);
   modport sink (input valid, encoded_word, last, output ready);
endinterface

`default_nettype wire

[rtl/core/pce_front.sv]
// front end: accepts items, tracks cursors and builds word jobs
`timescale 1ns / 1ps
`default_nettype none

module pce_front import pce_pkg::*; (
   input  wire logic      clock,
   input  wire logic      reset,
   pce_req_if.sink        req_bus,
   input  wire logic      csr_wr_en,
   input  wire field_type csr_wr_data,
   input  wire logic      queue_full,
   output logic           push,
   output job_type        push_job
);

   field_type new_size_ff;
   pos_type   new_cursor_ff, new_cursor_in;
   pos_type   old_cursor_ff, old_cursor_in;
   logic      started_ff, started_in;

   logic      accept;
   word_type  npos_w, opos_w, len_w, size_w, ncur_w, ocur_w;
   word_type  gap_w, seek_w, rest_w, nend_w, oend_w;
   logic      origin;

   assign req_bus.ready = !queue_full;
   assign accept        = req_bus.valid && !queue_full;
   assign push          = accept;

   always_comb begin
      npos_w = word_type'(req_bus.seg_new_pos);
      opos_w = word_type'(req_bus.seg_old_pos);
      len_w  = word_type'(req_bus.seg_length);
      size_w = word_type'(new_size_ff);
      ncur_w = word_type'(new_cursor_ff);
      ocur_w = word_type'(old_cursor_ff);
      gap_w  = npos_w - ncur_w;
      seek_w = opos_w - ocur_w;
      rest_w = size_w - ncur_w;
      nend_w = npos_w + len_w;
      oend_w = opos_w + len_w;
      origin = (req_bus.seg_new_pos == '0) && (req_bus.seg_old_pos == '0);
   end

   always_comb begin
      push_job       = '0;
      new_cursor_in  = new_cursor_ff;
      old_cursor_in  = old_cursor_ff;
      started_in     = started_ff;
      if (req_bus.command == CMD_SEGMENT) begin
         new_cursor_in = nend_w[POS_BITS-1:0];
         old_cursor_in = oend_w[POS_BITS-1:0];
         started_in    = 1'b1;
         priority if (!started_ff && origin) begin
            push_job.words[0] = len_w;
            push_job.last_idx = JOB_IDX_BITS'(0);
         end else if (!started_ff) begin
            push_job.words[1] = gap_w;
            push_job.words[2] = seek_w;
            push_job.words[3] = len_w;
            push_job.last_idx = JOB_IDX_BITS'(3);
         end else begin
            push_job.words[0] = gap_w;
            push_job.words[1] = seek_w;
            push_job.words[2] = len_w;
            push_job.last_idx = JOB_IDX_BITS'(2);
         end
      end else begin
         new_cursor_in = '0;
         old_cursor_in = '0;
         started_in    = 1'b0;
         push_job.fin  = 1'b1;
         if (!started_ff) begin
            push_job.words[1] = rest_w;
            push_job.last_idx = JOB_IDX_BITS'(2);
         end else begin
            push_job.words[0] = rest_w;
            push_job.last_idx = JOB_IDX_BITS'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         new_size_ff   <= '0;
         new_cursor_ff <= '0;
         old_cursor_ff <= '0;
         started_ff    <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            new_size_ff <= csr_wr_data;
         end
         if (accept) begin
            new_cursor_ff <= new_cursor_in;
            old_cursor_ff <= old_cursor_in;
            started_ff    <= started_in;
         end
      end
   end

endmodule

`default_nettype wire

[rtl/core/pce_queue.sv]
// short job queue between front and back
`timescale 1ns / 1ps
`default_nettype none

module pce_queue import pce_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  wire job_type push_job,
   output logic         full,
   input  wire logic    pop,
   output logic         empty,
   output job_type      head_job
);

   job_type                   entries_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_BITS-1:0] count_ff, count_in;

   assign full     = (count_ff == QUEUE_CNT_BITS'(QUEUE_DEPTH));
   assign empty    = (count_ff == '0);
   assign head_job = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QUEUE_PTR_BITS'(QUEUE_DEPTH - 1)) ? '0
                     : wr_ptr_ff + QUEUE_PTR_BITS'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QUEUE_PTR_BITS'(QUEUE_DEPTH - 1)) ? '0
                     : rd_ptr_ff + QUEUE_PTR_BITS'(1);
      end
      unique case ({push, pop})
         2'b10:   count_in = count_ff + QUEUE_CNT_BITS'(1);
         2'b01:   count_in = count_ff - QUEUE_CNT_BITS'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

`default_nettype wire

[rtl/core/pce_back.sv]
// back end: steps through job words and drives the result register
`timescale 1ns / 1ps
`default_nettype none

module pce_back import pce_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    empty,
   input  wire job_type head_job,
   output logic         pop,
   pce_rsp_if.source    rsp_bus
);

   logic [JOB_IDX_BITS-1:0] idx_ff, idx_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   word_type                rsp_word_ff, rsp_word_in;
   logic                    rsp_last_ff, rsp_last_in;
   logic                    load, emit, at_end;

   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.encoded_word = rsp_word_ff;
   assign rsp_bus.last         = rsp_last_ff;

   always_comb begin
      load         = !rsp_valid_ff || rsp_bus.ready;
      emit         = load && !empty;
      at_end       = (idx_ff == head_job.last_idx);
      pop          = emit && at_end;
      idx_in       = pop ? '0 : (emit ? idx_ff + JOB_IDX_BITS'(1) : idx_ff);
      rsp_valid_in = emit || (rsp_valid_ff && !rsp_bus.ready);
      rsp_word_in  = to_sign_mag(head_job.words[idx_ff]);
      rsp_last_in  = head_job.fin && at_end;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_word_ff <= rsp_word_in;
         rsp_last_ff <= rsp_last_in;
      end
   end

endmodule

`default_nettype wire

[rtl/core/patch_control_tuple_encoder_top.sv]
// top level of the patch control tuple encoder
//
//   channel   direction  handshake        payload
//   req_bus   in         valid / ready    command, seg_new_pos, seg_old_pos, seg_length
//   rsp_bus   out        valid / ready    encoded_word, last
//   csr       in         csr_wr_en        csr_wr_data (new_size)
//
// the result register sends one word per cycle unless stalled or the queue is empty:
// a segment is 3 words, a first segment away from the origin 4, at the origin 1, finish 2 or 3
// an item enters in any cycle the two-entry job queue has room and is registered in the queue
// reset clears cursors, the started flag, new_size, the queue pointers and the result valid flag
// a stalled result holds while the front keeps filling the queue
`timescale 1ns / 1ps
`default_nettype none

module patch_control_tuple_encoder_top import pce_pkg::*; (
   input  wire logic      clock,
   input  wire logic      reset,
   pce_req_if.sink        req_bus,
   pce_rsp_if.source      rsp_bus,
   input  wire logic      csr_wr_en,
   input  wire field_type csr_wr_data
);

   logic    push, pop, full, empty;
   job_type push_job, head_job;

   pce_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .queue_full  (full),
      .push        (push),
      .push_job    (push_job)
   );

   pce_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .full     (full),
      .pop      (pop),
      .empty    (empty),
      .head_job (head_job)
   );

   pce_back u_back (
      .clock    (clock),
      .reset    (reset),
      .empty    (empty),
      .head_job (head_job),
      .pop      (pop),
      .rsp_bus  (rsp_bus)
   );

endmodule

`default_nettype wire
